FILE: hdl/binomial_coefficient_defines.svh
// ----------------------------------------------------------------------------
// Binomial coefficient assertion macros
// Concurrent assertion helpers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_COEFFICIENT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_DEFINES_SVH

`ifndef ASSERT_OFF
`define BC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BC_ASSERT(lbl, clk, rstn, prop, msg)
`define BC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: hdl/bc_pkg.sv
// ----------------------------------------------------------------------------
// Binomial coefficient package
// Beat types, microcode word format and the microcode program.
// ----------------------------------------------------------------------------
package bc_pkg;

    typedef struct packed {
        logic signed [7:0] n_total;
        logic signed [7:0] k_chosen;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] coefficient;
        logic        overflow;
    } out_beat_t;

    localparam int PC_W    = 4;
    localparam int CNT_W   = 6;
    localparam int ACC_W   = 64;
    localparam int FACT_W  = 7;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t STEP_IDLE  = 4'd0;
    localparam pc_t STEP_CHECK = 4'd1;
    localparam pc_t STEP_TEST  = 4'd2;
    localparam pc_t STEP_MUL   = 4'd3;
    localparam pc_t STEP_OVCHK = 4'd4;
    localparam pc_t STEP_DIV   = 4'd5;
    localparam pc_t STEP_NEXT  = 4'd6;
    localparam pc_t STEP_ZERO  = 4'd7;
    localparam pc_t STEP_EMIT  = 4'd8;
    localparam pc_t STEP_RET   = 4'd9;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_DIV,
        OP_NEXT,
        OP_ZERO,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_INVALID,
        C_DONE,
        C_OVF,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    typedef struct packed {
        logic invalid;
        logic done;
        logic ovf;
        logic div_more;
        logic out_busy;
    } dp_status_t;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        case (pc)
            STEP_IDLE:  w = '{op: OP_LOAD, cond: C_NO_IN,      target: STEP_IDLE};
            STEP_CHECK: w = '{op: OP_NONE, cond: C_INVALID,    target: STEP_ZERO};
            STEP_TEST:  w = '{op: OP_NONE, cond: C_DONE,       target: STEP_EMIT};
            STEP_MUL:   w = '{op: OP_MUL,  cond: C_NEVER,      target: STEP_IDLE};
            STEP_OVCHK: w = '{op: OP_NONE, cond: C_OVF,        target: STEP_EMIT};
            STEP_DIV:   w = '{op: OP_DIV,  cond: C_DIV_MORE,   target: STEP_DIV};
            STEP_NEXT:  w = '{op: OP_NEXT, cond: C_ALWAYS,     target: STEP_TEST};
            STEP_ZERO:  w = '{op: OP_ZERO, cond: C_NEVER,      target: STEP_IDLE};
            STEP_EMIT:  w = '{op: OP_EMIT, cond: C_OUT_BUSY,   target: STEP_EMIT};
            STEP_RET:   w = '{op: OP_NONE, cond: C_ALWAYS,     target: STEP_IDLE};
            default:    w = '{op: OP_NONE, cond: C_ALWAYS,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/bc_sequencer.sv
// ----------------------------------------------------------------------------
// Binomial coefficient microsequencer
// Step counter, microcode lookup and conditional jump evaluation.
// ----------------------------------------------------------------------------
`include "binomial_coefficient_defines.svh"

module bc_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    input  bc_pkg::dp_status_t stat,
    output bc_pkg::op_t        op,
    output logic               src_ready
);
    import bc_pkg::*;

    pc_t    pc_reg;
    pc_t    pc_next;
    ucode_t uw;
    logic   take;

    assign uw = ucode_rom(pc_reg);

    always_comb
    begin
        case (uw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !src_valid;
            C_INVALID:  take = stat.invalid;
            C_DONE:     take = stat.done;
            C_OVF:      take = stat.ovf;
            C_DIV_MORE: take = stat.div_more;
            C_OUT_BUSY: take = stat.out_busy;
            default:    take = 1'b1;
        endcase
        pc_next = take ? uw.target : pc_reg + pc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

    assign op        = uw.op;
    assign src_ready = (pc_reg == STEP_IDLE);

    `BC_ASSERT(a_accept_goes_check, clk, rst_n, src_valid && src_ready |=> pc_reg == STEP_CHECK, "accepted beat did not start program")
    `BC_ASSERT_NEVER(a_pc_range, clk, rst_n, pc_reg > STEP_RET, "step counter out of program")

endmodule

FILE: hdl/bc_datapath.sv
// ----------------------------------------------------------------------------
// Binomial coefficient datapath
// Accumulator, 64x7 multiplier with overflow detect, restoring divider and
// output register.
// ----------------------------------------------------------------------------
`include "binomial_coefficient_defines.svh"

module bc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bc_pkg::op_t         op,
    input  bc_pkg::in_beat_t    src_data,
    output bc_pkg::dp_status_t  stat,
    output logic                res_valid,
    input  logic                res_ready,
    output bc_pkg::out_beat_t   res_data
);
    import bc_pkg::*;

    logic signed [7:0]          n_reg;
    logic signed [7:0]          k_reg;
    logic [7:0]                 i_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic                       ovf_reg;
    logic [FACT_W-1:0]          rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       res_valid_reg;
    out_beat_t                  res_data_reg;

    logic [7:0]                 factor_full;
    logic [FACT_W-1:0]          factor;
    logic [ACC_W+FACT_W-1:0]    prod;
    logic                       prod_ovf;
    logic [FACT_W:0]            rem_shift;
    logic                       qbit;
    logic [FACT_W:0]            rem_sub;
    logic                       emit_go;

    assign factor_full = n_reg - i_reg + 8'd1;
    assign factor      = factor_full[FACT_W-1:0];
    assign prod        = acc_reg * factor;
    assign prod_ovf    = |prod[ACC_W+FACT_W-1:ACC_W];

    assign rem_shift   = {rem_reg, acc_reg[ACC_W-1]};
    assign qbit        = (rem_shift >= i_reg);
    assign rem_sub     = rem_shift - i_reg;

    assign emit_go     = (op == OP_EMIT) && (!res_valid_reg || res_ready);

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                n_reg   <= src_data.n_total;
                k_reg   <= src_data.k_chosen;
                i_reg   <= 8'd1;
                acc_reg <= ACC_W'(1);
                ovf_reg <= 1'b0;
            end
            OP_MUL:
            begin
                if (prod_ovf)
                begin
                    acc_reg <= '1;
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= prod[ACC_W-1:0];
                end
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            OP_DIV:
            begin
                acc_reg <= {acc_reg[ACC_W-2:0], qbit};
                rem_reg <= qbit ? rem_sub[FACT_W-1:0] : rem_shift[FACT_W-1:0];
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            OP_NEXT:
            begin
                i_reg <= i_reg + 8'd1;
            end
            OP_ZERO:
            begin
                acc_reg <= '0;
                ovf_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (emit_go)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            res_data_reg.coefficient <= acc_reg;
            res_data_reg.overflow    <= ovf_reg;
        end
    end

    assign stat.invalid  = (k_reg < 0) || (k_reg > n_reg);
    assign stat.done     = (i_reg > $unsigned(k_reg));
    assign stat.ovf      = ovf_reg;
    assign stat.div_more = (cnt_reg != '1);
    assign stat.out_busy = res_valid_reg && !res_ready;

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    `BC_ASSERT(a_ovf_saturates, clk, rst_n, res_valid_reg && res_data_reg.overflow |-> res_data_reg.coefficient == '1, "overflow result not saturated")
    `BC_ASSERT(a_rem_below_div, clk, rst_n, op == OP_DIV |-> 8'(rem_reg) < i_reg, "divider remainder not below divisor")
    `BC_ASSERT(a_exact_div, clk, rst_n, op == OP_NEXT |-> rem_reg == '0, "division left a remainder")

endmodule

FILE: hdl/binomial_coefficient.sv
// ----------------------------------------------------------------------------
// Binomial coefficient
// C(n, k) by the multiplicative formula, saturating with a flag on overflow.
//
//   channel  dir  handshake              beat
//   src      in   src_valid/src_ready    n_total, k_chosen
//   res      out  res_valid/res_ready    coefficient, overflow
//
// One beat at a time. For a valid pair, each loop pass is one loop test, one
// multiply step, one overflow check, 64 single-bit steps of the restoring
// divider and one index step. An overflow ends the loop early.
// Invalid pairs skip the loop and give a zero coefficient.
// The result register frees the sequencer, so the next src beat is taken
// while a result waits on res_ready. Reset is asynchronous and needs no sweep.
// ----------------------------------------------------------------------------
module binomial_coefficient (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_ready,
    input  bc_pkg::in_beat_t  src_data,
    output logic              res_valid,
    input  logic              res_ready,
    output bc_pkg::out_beat_t res_data
);
    import bc_pkg::*;

    op_t        op;
    dp_status_t stat;

    bc_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .stat      (stat),
        .op        (op),
        .src_ready (src_ready)
    );

    bc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .src_data  (src_data),
        .stat      (stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule
